// File: design/mlpbgc_pkg.sv
package mlpbgc_pkg;

   // default network shape
   localparam int IN_COUNT_DEF    = 24;
   localparam int HIDDEN_A_DEF    = 16;
   localparam int HIDDEN_B_DEF    = 8;
   localparam int OUT_COUNT_DEF   = 4;
   localparam int WEIGHT_BITS_DEF = 16;

   // fixed field widths
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 16;
   localparam int PIXEL_W = 24;
   localparam int ACT_W   = 16;
   localparam int CODE_W  = 4;

   // request kinds
   localparam logic REQ_WRITE    = 1'b0;
   localparam logic REQ_CLASSIFY = 1'b1;

   // layer codes
   localparam logic [1:0] LYR_A   = 2'd0;
   localparam logic [1:0] LYR_B   = 2'd1;
   localparam logic [1:0] LYR_OUT = 2'd2;

   localparam logic [ACT_W-1:0] HALF_Q16 = 16'd32768;

   // sigmoid samples at steps of 0.5 over [0, 8], Q0.16
   function automatic logic [ACT_W-1:0] sig_table(input logic [4:0] idx);
      logic [ACT_W-1:0] t;
      case (idx)
         5'd0:    t = 16'd32768;
         5'd1:    t = 16'd40794;
         5'd2:    t = 16'd47911;
         5'd3:    t = 16'd53581;
         5'd4:    t = 16'd57724;
         5'd5:    t = 16'd60565;
         5'd6:    t = 16'd62428;
         5'd7:    t = 16'd63615;
         5'd8:    t = 16'd64357;
         5'd9:    t = 16'd64816;
         5'd10:   t = 16'd65097;
         5'd11:   t = 16'd65269;
         5'd12:   t = 16'd65374;
         5'd13:   t = 16'd65438;
         5'd14:   t = 16'd65476;
         5'd15:   t = 16'd65500;
         default: t = 16'd65514;
      endcase
      return t;
   endfunction

endpackage

// File: design/mlp_binary_glyph_classifier.sv
// Weight write: one beat, accepted while the sequencer is idle, no response.
// Classify: each neuron runs its fan-in through one weight-memory read per
// multiply-accumulate; the finished response is handed to the output register.
// One classification in flight; a finished response may wait while writes run.
// Synchronous reset clears control only; weight memory is undefined until written.
module mlp_binary_glyph_classifier #(
   parameter int IN_COUNT    = mlpbgc_pkg::IN_COUNT_DEF,
   parameter int HIDDEN_A    = mlpbgc_pkg::HIDDEN_A_DEF,
   parameter int HIDDEN_B    = mlpbgc_pkg::HIDDEN_B_DEF,
   parameter int OUT_COUNT   = mlpbgc_pkg::OUT_COUNT_DEF,
   parameter int WEIGHT_BITS = mlpbgc_pkg::WEIGHT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic [mlpbgc_pkg::INDEX_W-1:0]      req_weight_index,
   input  logic signed [mlpbgc_pkg::VALUE_W-1:0] req_weight_value,
   input  logic [mlpbgc_pkg::PIXEL_W-1:0]      req_pixels,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mlpbgc_pkg::CODE_W-1:0]       rsp_class_code,
   output logic [mlpbgc_pkg::ACT_W-1:0]        rsp_act_zero,
   output logic [mlpbgc_pkg::ACT_W-1:0]        rsp_act_one,
   output logic [mlpbgc_pkg::ACT_W-1:0]        rsp_act_two,
   output logic [mlpbgc_pkg::ACT_W-1:0]        rsp_act_three
);
   import mlpbgc_pkg::*;

   localparam int LB_BASE = IN_COUNT * HIDDEN_A;
   localparam int LO_BASE = LB_BASE + HIDDEN_A * HIDDEN_B;
   localparam int TOTAL_W = LO_BASE + HIDDEN_B * OUT_COUNT;
   localparam int AW      = $clog2(TOTAL_W);
   localparam int IXW     = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
   localparam int ACT_D   = HIDDEN_A + HIDDEN_B;
   localparam int AAW     = $clog2(ACT_D);
   localparam int CW      = 7;
   localparam int OPW     = ACT_W + 1;
   localparam int PW      = WEIGHT_BITS + OPW + 1;
   localparam int ACCW    = PW + 7;

   localparam logic signed [ACCW-1:0] SAT_HI = ACCW'(64'sd2147483648);
   localparam logic signed [ACCW-1:0] SAT_LO = ACCW'(-64'sd2147483648);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_MAC   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_SQ    = 3'd4;
   localparam logic [2:0] ST_SIG   = 3'd5;
   localparam logic [2:0] ST_FIN   = 3'd6;

   // memories
   logic [WEIGHT_BITS-1:0] w_mem [TOTAL_W];
   logic [ACT_W-1:0]       a_mem [ACT_D];

   logic [2:0]              state_ff, state_in;
   logic [1:0]              layer_ff, layer_in;
   logic [CW-1:0]           i_ff, i_in, j_ff, j_in;
   logic [AW-1:0]           waddr_ff, waddr_in;
   logic [IN_COUNT-1:0]     pix_ff;
   logic                    v1_ff, v1_in, v2_ff;
   logic                    pbit_ff;
   logic [WEIGHT_BITS-1:0]  w_rd_ff;
   logic [ACT_W-1:0]        a_rd_ff;
   logic signed [PW-1:0]    prod_ff;
   logic signed [ACCW-1:0]  acc_ff, acc_in;
   logic signed [ACT_W-1:0] s_ff;
   logic [ACT_W-1:0]        out_act_ff [OUT_COUNT];
   logic [OUT_COUNT-1:0]    code_ff;
   logic                    rsp_valid_ff;
   logic [CODE_W-1:0]       rsp_code_ff;
   logic [ACT_W-1:0]        rsp_act_ff [4];

   logic [CW-1:0]  n_in, n_out;
   logic [AW-1:0]  base, stride;
   logic [AAW-1:0] a_raddr, a_waddr;
   logic           w_we, in_acc;
   logic [IXW-1:0] idx_ext;
   logic [63:0]    pix_ext;
   logic [IN_COUNT-1:0] pix_sh;
   logic [ACT_W-1:0]    sig_v;

   // per-layer shape
   always_comb begin
      case (layer_ff)
         LYR_A: begin
            n_in = CW'(IN_COUNT);  n_out = CW'(HIDDEN_A);
            base = '0;             stride = AW'(HIDDEN_A);
         end
         LYR_B: begin
            n_in = CW'(HIDDEN_A);  n_out = CW'(HIDDEN_B);
            base = AW'(LB_BASE);   stride = AW'(HIDDEN_B);
         end
         default: begin
            n_in = CW'(HIDDEN_B);  n_out = CW'(OUT_COUNT);
            base = AW'(LO_BASE);   stride = AW'(OUT_COUNT);
         end
      endcase
   end

   assign in_acc    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign idx_ext   = IXW'(req_weight_index);
   assign w_we      = in_acc && (req_type == REQ_WRITE) && (idx_ext < IXW'(TOTAL_W));
   assign pix_ext   = 64'(req_pixels);
   assign pix_sh    = pix_ff >> i_ff;
   assign a_raddr   = (layer_ff == LYR_B) ? AAW'(i_ff) : AAW'(HIDDEN_A + int'(i_ff));
   assign a_waddr   = (layer_ff == LYR_A) ? AAW'(j_ff) : AAW'(HIDDEN_A + int'(j_ff));

   // weight memory: write on write beat, read one address per cycle
   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[idx_ext[AW-1:0]] <= WEIGHT_BITS'(req_weight_value);
      end
      w_rd_ff <= w_mem[waddr_ff];
   end

   // activation memory for both hidden layers
   always_ff @(posedge clock) begin
      if (state_ff == ST_SIG && layer_ff != LYR_OUT) begin
         a_mem[a_waddr] <= sig_v;
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   // multiply stage: pixel counts as 1.0, activation as Q0.16
   always_ff @(posedge clock) begin
      logic [OPW-1:0] op;
      op = (layer_ff == LYR_A) ? {pbit_ff, {ACT_W{1'b0}}} : {1'b0, a_rd_ff};
      pbit_ff <= pix_sh[0];
      prod_ff <= PW'($signed(w_rd_ff) * $signed({1'b0, op}));
   end

   // sigmoid by table with linear interpolation
   always_comb begin
      logic [ACT_W-1:0] m, t0, t1, v;
      logic [4:0]       k;
      logic [26:0]      fr;
      m  = s_ff[ACT_W-1] ? ACT_W'(-s_ff) : ACT_W'(s_ff);
      k  = m[15:11];
      t0 = sig_table(k);
      t1 = sig_table(k + 5'd1);
      fr = 27'(t1 - t0) * 27'(m[10:0]) + 27'd1024;
      v  = (k >= 5'd16) ? t0 : t0 + ACT_W'(fr >> 11);
      sig_v = s_ff[ACT_W-1] ? ACT_W'(17'h10000 - 17'(v)) : v;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      layer_in = layer_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      waddr_in = waddr_ff;
      v1_in    = 1'b0;
      acc_in   = acc_ff;
      if (v2_ff) begin
         acc_in = acc_ff + ACCW'(prod_ff);
      end
      case (state_ff)
         ST_IDLE: begin
            if (in_acc && req_type == REQ_CLASSIFY) begin
               state_in = ST_START;
               layer_in = LYR_A;
               j_in     = '0;
            end
         end
         ST_START: begin
            waddr_in = base + AW'(j_ff);
            i_in     = '0;
            acc_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            v1_in    = 1'b1;
            waddr_in = waddr_ff + stride;
            i_in     = i_ff + CW'(1);
            if (i_ff + CW'(1) == n_in) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_SIG;
         end
         ST_SIG: begin
            if (j_ff + CW'(1) != n_out) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_START;
            end else if (layer_ff != LYR_OUT) begin
               j_in     = '0;
               layer_in = layer_ff + 2'd1;
               state_in = ST_START;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= v1_in;
         v2_ff    <= v1_ff;
      end
      layer_ff <= layer_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      waddr_ff <= waddr_in;
      acc_ff   <= acc_in;
      if (in_acc && req_type == REQ_CLASSIFY) begin
         pix_ff <= pix_ext[IN_COUNT-1:0];
      end
   end

   // saturate Q.28 sum to Q4.12
   always_ff @(posedge clock) begin
      if (state_ff == ST_SQ || state_ff == ST_DRAIN) begin
         if (acc_ff >= SAT_HI) begin
            s_ff <= 16'sh7FFF;
         end else if (acc_ff < SAT_LO) begin
            s_ff <= 16'sh8000;
         end else begin
            s_ff <= acc_ff[31:16];
         end
      end
   end

   // output activations shift in, output 0 ends at entry 0 and code MSB
   always_ff @(posedge clock) begin
      if (state_ff == ST_SIG && layer_ff == LYR_OUT) begin
         for (int k = 0; k < OUT_COUNT - 1; k++) begin
            out_act_ff[k] <= out_act_ff[k+1];
         end
         out_act_ff[OUT_COUNT-1] <= sig_v;
         code_ff <= OUT_COUNT'({code_ff, (sig_v > HALF_Q16)});
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (state_ff == ST_FIN && (!rsp_valid_ff || rsp_ready)) begin
         rsp_code_ff <= CODE_W'(32'(code_ff));
         for (int k = 0; k < 4; k++) begin
            rsp_act_ff[k] <= (k < OUT_COUNT) ? out_act_ff[(k < OUT_COUNT) ? k : 0] : '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_class_code = rsp_code_ff;
   assign rsp_act_zero   = rsp_act_ff[0];
   assign rsp_act_one    = rsp_act_ff[1];
   assign rsp_act_two    = rsp_act_ff[2];
   assign rsp_act_three  = rsp_act_ff[3];

   // product beat always follows a read beat
   a_pipe: assert property (@(posedge clock) disable iff (reset) v2_ff |-> $past(v1_ff))
      else $error("product without read");
   // saturation only sees a drained accumulator
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ) |-> (!v1_ff && !v2_ff))
      else $error("accumulator not drained");
   // new requests only while sequencer idles
   a_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> !req_ready)
      else $error("ready while busy");
endmodule
